// File: rtl/hdlc_channel_frame_restuffer_macros.svh
// Assertion macros used by the restuffer output buffer.
`ifndef HDLC_CHANNEL_FRAME_RESTUFFER_MACROS_SVH
`define HDLC_CHANNEL_FRAME_RESTUFFER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HCFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define HCFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/hcfr_pkg.sv
// Shared constants and types of the HDLC channel frame restuffer.
package hcfr_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE = 8'h7D;
	localparam logic [7:0] XOR_MASK = 8'h20;
	localparam logic [7:0] CHAN_RESET = 8'd4;
	localparam int MAX_FRAME_DEF = 512;
	localparam int MAX_RESULTS = 5;
	localparam int IDX_W = 3;

	typedef enum logic [1:0] {
		MODE_WAIT = 2'd0,
		MODE_FRAME = 2'd1,
		MODE_ESC = 2'd2
	} rx_mode_t;

	typedef struct packed {
		logic [IDX_W-1:0] count;
		logic [MAX_RESULTS-1:0][7:0] bytes;
	} result_list_t;

endpackage

// File: rtl/hdlc_channel_frame_restuffer.sv
// Top level of the HDLC channel frame restuffer.
// A received byte is accepted when the output buffer is free; the state update and the whole
// list of words it causes (none to five) are computed in that cycle and land in a result
// register, which then hands out one word per cycle while out_stall is low. The next byte is
// taken in the same cycle as the last word of the list leaves; bytes that cause no word or
// one word go at one per cycle when the output does not stall. The output word register is
// what limits the input rate. The last flag marks the final word caused by one input byte.
module hdlc_channel_frame_restuffer #(
	parameter int MAX_FRAME = hcfr_pkg::MAX_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last
);
	import hcfr_pkg::*;

	result_list_t res;
	logic free;
	logic accept;

	assign in_stall = !free;
	assign accept = in_valid && free;

	hcfr_decode #(
		.MAX_FRAME(MAX_FRAME)
	) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.accept(accept),
		.in_byte(in_byte),
		.res(res)
	);

	hcfr_outbuf u_outbuf (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept && res.count != '0),
		.res(res),
		.free(free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last(last)
	);

endmodule

// File: rtl/hcfr_decode.sv
// Receive state and per-byte computation of the list of words to send.
module hcfr_decode #(
	parameter int MAX_FRAME = hcfr_pkg::MAX_FRAME_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [7:0]           cfg_wr_data,
	input  logic                 accept,
	input  logic [7:0]           in_byte,
	output hcfr_pkg::result_list_t res
);
	import hcfr_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	rx_mode_t mode_q, mode_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0] held_q, held_d;
	logic drop_q, drop_d;
	logic [7:0] chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WAIT;
			cnt_q <= '0;
			held_q <= '0;
			drop_q <= 1'b0;
			chan_q <= CHAN_RESET;
		end else begin
			if (cfg_wr_en) begin
				chan_q <= cfg_wr_data;
			end
			if (accept) begin
				mode_q <= mode_d;
				cnt_q <= cnt_d;
				held_q <= held_d;
				drop_q <= drop_d;
			end
		end
	end

	always_comb begin
		logic keep;
		logic [7:0] kept;
		logic [IDX_W-1:0] p;
		res = '0;
		mode_d = mode_q;
		cnt_d = cnt_q;
		held_d = held_q;
		drop_d = drop_q;
		keep = 1'b0;
		kept = in_byte;
		p = '0;
		case (mode_q)
			MODE_WAIT: begin
				if (in_byte == FLAG_BYTE) begin
					mode_d = MODE_FRAME;
					cnt_d = '0;
					drop_d = 1'b0;
				end else begin
					res.bytes[0] = in_byte;
					res.count = IDX_W'(1);
				end
			end
			MODE_ESC: begin
				keep = 1'b1;
				kept = in_byte ^ XOR_MASK;
				mode_d = MODE_FRAME;
			end
			MODE_FRAME: begin
				if (in_byte == FLAG_BYTE) begin
					if (cnt_q >= CNT_W'(2) && !drop_q) begin
						res.bytes[0] = FLAG_BYTE;
						res.count = IDX_W'(1);
					end
					cnt_d = '0;
					drop_d = 1'b0;
				end else if (in_byte == ESC_BYTE) begin
					mode_d = MODE_ESC;
				end else begin
					keep = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_WAIT;
			end
		endcase

		if (keep && cnt_q < CNT_W'(MAX_FRAME)) begin
			if (cnt_q == '0) begin
				held_d = kept;
			end else if (cnt_q == CNT_W'(1)) begin
				drop_d = (held_q == chan_q);
				if (!drop_d) begin
					res.bytes[0] = FLAG_BYTE;
					p = IDX_W'(1);
					if (held_q == FLAG_BYTE || held_q == ESC_BYTE) begin
						res.bytes[p] = ESC_BYTE;
						res.bytes[p + IDX_W'(1)] = held_q ^ XOR_MASK;
						p = p + IDX_W'(2);
					end else begin
						res.bytes[p] = held_q;
						p = p + IDX_W'(1);
					end
				end
			end
			if (cnt_q != '0 && !drop_d) begin
				if (kept == FLAG_BYTE || kept == ESC_BYTE) begin
					res.bytes[p] = ESC_BYTE;
					res.bytes[p + IDX_W'(1)] = kept ^ XOR_MASK;
					res.count = p + IDX_W'(2);
				end else begin
					res.bytes[p] = kept;
					res.count = p + IDX_W'(1);
				end
			end
			cnt_d = cnt_q + CNT_W'(1);
		end
	end

endmodule

// File: rtl/hcfr_outbuf.sv
// Result register that hands out the words of one input byte, one per cycle while out_stall is low.
module hcfr_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  hcfr_pkg::result_list_t res,
	output logic                   free,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             out_byte,
	output logic                   last
);
	import hcfr_pkg::*;

	logic busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cnt_q;
	logic [MAX_RESULTS-1:0][7:0] bytes_q;
	logic take;

	assign out_valid = busy_q;
	assign last = (idx_q == cnt_q - IDX_W'(1));
	assign out_byte = bytes_q[idx_q];
	assign take = busy_q && !out_stall;
	assign free = !busy_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (take) begin
				if (last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cnt_q <= res.count;
			bytes_q <= res.bytes;
		end
	end

	`include "hdlc_channel_frame_restuffer_macros.svh"

	`HCFR_ASSERT_NOW(a_idx_in_range, busy_q, idx_q < cnt_q, "word index beyond list")
	`HCFR_ASSERT_NOW(a_load_when_free, load, free, "list loaded over unsent words")
	`HCFR_ASSERT_NEXT(a_more_words, take && !last, out_valid, "word list cut short")
	`HCFR_ASSERT_NOW(a_load_nonempty, load, res.count != '0, "empty list loaded")

endmodule
